// ===== hw/rtl/pptl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptl_pkg
// Shared types and constants of the periodic point triangle locator.
// ----------------------------------------------------------------------------
package pptl_pkg;

	localparam int COORD_BITS  = 24;
	localparam int TABLE_DEPTH = 256;
	localparam int SLOT_BITS   = 8;
	localparam int PERIOD_BITS = 23;
	localparam int COUNT_BITS  = 9;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * DIFF_BITS;
	localparam int ENTRY_BITS  = 6 * COORD_BITS;
	localparam int DIV_STEPS   = COORD_BITS;
	localparam int STEP_BITS   = $clog2(DIV_STEPS);
	localparam int CFG_IDX_BITS = 2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TRIANGLE_COUNT = 2'd2;

	localparam logic [PERIOD_BITS-1:0] CELL_RESET  = 23'd256;
	localparam logic [COUNT_BITS-1:0]  COUNT_RESET = 9'd0;
	localparam logic [COUNT_BITS-1:0]  COUNT_LIMIT = COUNT_BITS'(TABLE_DEPTH);

	typedef struct packed {
		logic                         cmd;
		logic [SLOT_BITS-1:0]         slot;
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [PERIOD_BITS-1:0]       wx;
		logic [PERIOD_BITS-1:0]       wy;
	} pptl_item_t;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
	typedef enum logic {B_IDLE, B_SCAN} back_state_t;

endpackage

// ===== hw/rtl/pptl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptl_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module pptl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/pptl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptl_front
// Accepts transactions, wraps query points into the unit cell with a
// bit-serial remainder, and hands the classified item to the queue.
// ----------------------------------------------------------------------------
module pptl_front import pptl_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [SLOT_BITS-1:0]         slot,
	input  logic signed [COORD_BITS-1:0] corner_a_x,
	input  logic signed [COORD_BITS-1:0] corner_a_y,
	input  logic signed [COORD_BITS-1:0] corner_b_x,
	input  logic signed [COORD_BITS-1:0] corner_b_y,
	input  logic signed [COORD_BITS-1:0] corner_c_x,
	input  logic signed [COORD_BITS-1:0] corner_c_y,
	input  logic signed [COORD_BITS-1:0] probe_x,
	input  logic signed [COORD_BITS-1:0] probe_y,
	input  logic [PERIOD_BITS-1:0]       cell_width,
	input  logic [PERIOD_BITS-1:0]       cell_height,
	output logic                         push_valid,
	input  logic                         push_ready,
	output pptl_item_t                   push_item
);

	front_state_t           state_q, state_d;
	pptl_item_t             item_q;
	logic [COORD_BITS-1:0]  mag_x_q, mag_y_q;
	logic [PERIOD_BITS-1:0] rem_x_q, rem_y_q;
	logic                   neg_x_q, neg_y_q;
	logic [STEP_BITS-1:0]   step_q;
	logic                   accept;

	function automatic logic [PERIOD_BITS-1:0] rem_step(
		input logic [PERIOD_BITS-1:0] rem,
		input logic                   bit_in,
		input logic [PERIOD_BITS-1:0] p
	);
		logic [PERIOD_BITS:0] t;
		t = {rem, bit_in};
		if (t >= {1'b0, p}) begin
			rem_step = PERIOD_BITS'(t - {1'b0, p});
		end else begin
			rem_step = t[PERIOD_BITS-1:0];
		end
	endfunction

	function automatic logic [PERIOD_BITS-1:0] wrap_fin(
		input logic [PERIOD_BITS-1:0] rem,
		input logic                   neg,
		input logic [PERIOD_BITS-1:0] p
	);
		if (p == '0) begin
			wrap_fin = '0;
		end else if (rem == '0) begin
			wrap_fin = neg ? '0 : p;
		end else begin
			wrap_fin = neg ? PERIOD_BITS'(p - rem) : rem;
		end
	endfunction

	assign in_ready   = (state_q == F_IDLE);
	assign accept     = in_valid && in_ready;
	assign push_valid = (state_q == F_PUSH);

	always_comb begin
		push_item    = item_q;
		push_item.wx = wrap_fin(rem_x_q, neg_x_q, cell_width);
		push_item.wy = wrap_fin(rem_y_q, neg_y_q, cell_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (cmd == CMD_QUERY) ? F_DIV : F_PUSH;
				end
			end
			F_DIV: begin
				if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.cmd  <= cmd;
			item_q.slot <= slot;
			item_q.ax   <= corner_a_x;
			item_q.ay   <= corner_a_y;
			item_q.bx   <= corner_b_x;
			item_q.by   <= corner_b_y;
			item_q.cx   <= corner_c_x;
			item_q.cy   <= corner_c_y;
			item_q.wx   <= '0;
			item_q.wy   <= '0;
			// magnitude of the probe; the most negative value still fits unsigned
			mag_x_q <= probe_x[COORD_BITS-1] ? COORD_BITS'(-probe_x) : probe_x;
			mag_y_q <= probe_y[COORD_BITS-1] ? COORD_BITS'(-probe_y) : probe_y;
			neg_x_q <= probe_x[COORD_BITS-1] || (probe_x == '0);
			neg_y_q <= probe_y[COORD_BITS-1] || (probe_y == '0);
			rem_x_q <= '0;
			rem_y_q <= '0;
			step_q  <= '0;
		end else if (state_q == F_DIV) begin
			rem_x_q <= rem_step(rem_x_q, mag_x_q[COORD_BITS-1], cell_width);
			rem_y_q <= rem_step(rem_y_q, mag_y_q[COORD_BITS-1], cell_height);
			mag_x_q <= {mag_x_q[COORD_BITS-2:0], 1'b0};
			mag_y_q <= {mag_y_q[COORD_BITS-2:0], 1'b0};
			step_q  <= step_q + 1'b1;
		end
	end

endmodule

// ===== hw/rtl/pptl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptl_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module pptl_queue import pptl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  pptl_item_t push_item,
	output logic       pop_valid,
	input  logic       pop_ready,
	output pptl_item_t pop_item
);

	pptl_item_t  slots_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push, pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hw/rtl/pptl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptl_back
// Writes loaded triangles to the table and scans it for queries, one
// triangle per cycle through a read, multiply and compare pipeline.
// ----------------------------------------------------------------------------
module pptl_back import pptl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  pptl_item_t             pop_item,
	input  logic [COUNT_BITS-1:0]  triangle_count,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic [SLOT_BITS-1:0]   hit_slot,
	output logic [PERIOD_BITS-1:0] wrapped_x,
	output logic [PERIOD_BITS-1:0] wrapped_y
);

	back_state_t            state_q, state_d;
	logic [COUNT_BITS-1:0]  cnt_q, limit_q;
	logic [PERIOD_BITS-1:0] px_q, py_q;
	logic                   v_s1_q, v_s2_q;
	logic [SLOT_BITS-1:0]   idx_s1_q, idx_s2_q;
	logic signed [PROD_BITS-1:0] p_s2_q [4];
	logic signed [PROD_BITS-1:0] q_s2_q [4];
	logic                   out_valid_q, hit_q;
	logic [SLOT_BITS-1:0]   hit_slot_q;
	logic [PERIOD_BITS-1:0] wrapped_x_q, wrapped_y_q;

	logic                   wr_en, rd_en, issue, start, done, found;
	logic [ENTRY_BITS-1:0]  wr_data, rd_data;
	logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, px, py;
	logic signed [DIFF_BITS-1:0]  bax, bay, cax, cay, bpx, bpy, cpx, cpy, pax, pay;
	logic [3:0]             gt, lt;
	logic                   match;

	assign wr_data = {pop_item.ax, pop_item.ay, pop_item.bx,
	                  pop_item.by, pop_item.cx, pop_item.cy};

	pptl_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pop_item.slot),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (cnt_q[SLOT_BITS-1:0]),
		.rd_data (rd_data)
	);

	assign {ax, ay, bx, by, cx, cy} = rd_data;
	assign px = COORD_BITS'({1'b0, px_q});
	assign py = COORD_BITS'({1'b0, py_q});

	assign bax = DIFF_BITS'(bx) - DIFF_BITS'(ax);
	assign bay = DIFF_BITS'(by) - DIFF_BITS'(ay);
	assign cax = DIFF_BITS'(cx) - DIFF_BITS'(ax);
	assign cay = DIFF_BITS'(cy) - DIFF_BITS'(ay);
	assign bpx = DIFF_BITS'(bx) - DIFF_BITS'(px);
	assign bpy = DIFF_BITS'(by) - DIFF_BITS'(py);
	assign cpx = DIFF_BITS'(cx) - DIFF_BITS'(px);
	assign cpy = DIFF_BITS'(cy) - DIFF_BITS'(py);
	assign pax = DIFF_BITS'(px) - DIFF_BITS'(ax);
	assign pay = DIFF_BITS'(py) - DIFF_BITS'(ay);

	// entry 0 is the orientation of the triangle itself
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			gt[k] = p_s2_q[k] > q_s2_q[k];
			lt[k] = p_s2_q[k] < q_s2_q[k];
		end
		match = gt[0] || lt[0];
		for (int k = 1; k < 4; k++) begin
			if ((gt[k] && lt[0]) || (lt[k] && gt[0])) begin
				match = 1'b0;
			end
		end
	end

	assign issue = (state_q == B_SCAN) && (cnt_q < limit_q);
	assign found = (state_q == B_SCAN) && v_s2_q && match;
	assign done  = found || ((state_q == B_SCAN) && !issue && !v_s1_q && !v_s2_q);
	assign rd_en = issue;

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		wr_en     = 1'b0;
		start     = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					if (pop_item.cmd == CMD_LOAD) begin
						pop_ready = 1'b1;
						wr_en     = 1'b1;
					end else if (!out_valid_q) begin
						pop_ready = 1'b1;
						start     = 1'b1;
						state_d   = B_SCAN;
					end
				end
			end
			B_SCAN: begin
				if (done) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// drop work still in flight once the search ends
			v_s1_q  <= issue && !done;
			v_s2_q  <= v_s1_q && !done;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q   <= '0;
			limit_q <= (triangle_count > COUNT_LIMIT) ? COUNT_LIMIT : triangle_count;
			px_q    <= pop_item.wx;
			py_q    <= pop_item.wy;
		end else if (issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
		idx_s1_q  <= cnt_q[SLOT_BITS-1:0];
		idx_s2_q  <= idx_s1_q;
		p_s2_q[0] <= bax * cay;
		q_s2_q[0] <= cax * bay;
		p_s2_q[1] <= bpx * cpy;
		q_s2_q[1] <= cpx * bpy;
		p_s2_q[2] <= bax * pay;
		q_s2_q[2] <= pax * bay;
		p_s2_q[3] <= pax * cay;
		q_s2_q[3] <= cax * pay;
		if (done) begin
			hit_q       <= found;
			hit_slot_q  <= found ? idx_s2_q : '0;
			wrapped_x_q <= px_q;
			wrapped_y_q <= py_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign hit_slot  = hit_slot_q;
	assign wrapped_x = wrapped_x_q;
	assign wrapped_y = wrapped_y_q;

endmodule

// ===== hw/rtl/periodic_point_triangle_locator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_point_triangle_locator
// Triangle table with periodic point location by barycentric sign tests.
// ----------------------------------------------------------------------------
// A load transaction (cmd 0) writes one triangle to the table and returns
// nothing; a query (cmd 1) returns one result. A query first passes through
// the front wrapping the probe into the unit cell with a one-bit-per-cycle
// remainder, then the back reads the table one triangle per cycle from its
// memory port, up to min(triangle_count, 256) triangles, stopping early
// when a triangle matches. A two-entry queue lets the front take the next
// transaction while the back is still searching. Table entries hold nothing
// until loaded; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module periodic_point_triangle_locator import pptl_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [PERIOD_BITS-1:0]       cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [SLOT_BITS-1:0]         slot,
	input  logic signed [COORD_BITS-1:0] corner_a_x,
	input  logic signed [COORD_BITS-1:0] corner_a_y,
	input  logic signed [COORD_BITS-1:0] corner_b_x,
	input  logic signed [COORD_BITS-1:0] corner_b_y,
	input  logic signed [COORD_BITS-1:0] corner_c_x,
	input  logic signed [COORD_BITS-1:0] corner_c_y,
	input  logic signed [COORD_BITS-1:0] probe_x,
	input  logic signed [COORD_BITS-1:0] probe_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [SLOT_BITS-1:0]         hit_slot,
	output logic [PERIOD_BITS-1:0]       wrapped_x,
	output logic [PERIOD_BITS-1:0]       wrapped_y
);

	logic [PERIOD_BITS-1:0] cell_width_q, cell_height_q;
	logic [COUNT_BITS-1:0]  triangle_count_q;
	logic                   push_valid, push_ready, pop_valid, pop_ready;
	pptl_item_t             push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q     <= CELL_RESET;
			cell_height_q    <= CELL_RESET;
			triangle_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CELL_WIDTH:     cell_width_q     <= cfg_data;
				CFG_CELL_HEIGHT:    cell_height_q    <= cfg_data;
				CFG_TRIANGLE_COUNT: triangle_count_q <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	pptl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.slot        (slot),
		.corner_a_x  (corner_a_x),
		.corner_a_y  (corner_a_y),
		.corner_b_x  (corner_b_x),
		.corner_b_y  (corner_b_y),
		.corner_c_x  (corner_c_x),
		.corner_c_y  (corner_c_y),
		.probe_x     (probe_x),
		.probe_y     (probe_y),
		.cell_width  (cell_width_q),
		.cell_height (cell_height_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	pptl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	pptl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_item       (pop_item),
		.triangle_count (triangle_count_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.hit_slot       (hit_slot),
		.wrapped_x      (wrapped_x),
		.wrapped_y      (wrapped_y)
	);

endmodule
